// ===== rtl/mbc_pkg.sv =====
// Shared types and constants for the perceptron classifier.
// No dependencies; every other file imports this package.
package mbc_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int ACC_BITS    = 40;
    localparam int SCORE_W     = 32;
    localparam int PARAM_DEPTH = 512;
    localparam int PADDR_W     = $clog2(PARAM_DEPTH);
    localparam int PROD_W      = 2 * DATA_WIDTH;

    // Stream word layout
    localparam int OP_W        = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    // Item kinds carried on tuser
    localparam logic [OP_W-1:0] OP_PARAM   = 2'd0;
    localparam logic [OP_W-1:0] OP_FEATURE = 2'd1;
    localparam logic [OP_W-1:0] OP_START   = 2'd2;

    // Cycles from operand issue until the accumulator holds the sum
    localparam int MAC_LATENCY = 3;
    localparam int DRAIN_W     = $clog2(MAC_LATENCY);

    localparam logic signed [ACC_BITS-1:0] RELU_MAX =
        {{(ACC_BITS-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SCORE_MAX =
        {{(ACC_BITS-SCORE_W+1){1'b0}}, {(SCORE_W-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SCORE_MIN =
        {{(ACC_BITS-SCORE_W+1){1'b1}}, {(SCORE_W-1){1'b0}}};

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic valid;   // operands issued this cycle
        logic bias;    // load bias instead of accumulating a product
        logic zero;    // parameter address beyond the store, read as zero
    } t_mac_ctl;

endpackage

// ===== rtl/mbc_param_mem.sv =====
// Parameter store: weights and biases, one write and one registered read port.
// Depends on mbc_pkg.
module mbc_param_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [mbc_pkg::PADDR_W-1:0] i_waddr,
    input  mbc_pkg::t_data              i_wdata,
    input  logic [mbc_pkg::PADDR_W-1:0] i_raddr,
    output mbc_pkg::t_data              o_rdata
);
    import mbc_pkg::*;

    t_data r_mem [PARAM_DEPTH];
    t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mbc_mac.sv =====
// Shared multiply-accumulate unit with fixed-point rescale, ReLU and score saturation.
// Depends on mbc_pkg.
module mbc_mac #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mbc_pkg::t_mac_ctl                  i_ctl,
    input  mbc_pkg::t_data                     i_w,
    input  mbc_pkg::t_data                     i_x,
    output mbc_pkg::t_data                     o_relu,
    output logic signed [mbc_pkg::SCORE_W-1:0] o_score
);
    import mbc_pkg::*;

    t_mac_ctl                    r_ctl_b;
    t_mac_ctl                    r_ctl_c;
    logic signed [PROD_W-1:0]    r_prod;
    t_data                       r_bias;
    logic signed [ACC_BITS-1:0]  r_acc;

    t_data                       w_eff;
    logic signed [ACC_BITS-1:0]  bias_ext;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  shifted;

    assign w_eff = r_ctl_b.zero ? t_data'(0) : i_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_b <= '0;
            r_ctl_c <= '0;
            r_acc   <= '0;
        end else begin
            r_ctl_b <= i_ctl;
            r_ctl_c <= r_ctl_b;
            if (r_ctl_c.valid) begin
                r_acc <= r_ctl_c.bias ? bias_ext : r_acc + prod_ext;
            end
        end
    end

    // operand stage: one multiply, registered
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_eff) * PROD_W'(i_x);
        r_bias <= w_eff;
    end

    assign bias_ext = {{(ACC_BITS-DATA_WIDTH){r_bias[DATA_WIDTH-1]}}, r_bias} <<< FRAC_BITS;
    assign prod_ext = {{(ACC_BITS-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // arithmetic shift floors toward minus infinity
    assign shifted = r_acc >>> FRAC_BITS;

    always_comb begin
        priority if (shifted[ACC_BITS-1]) begin
            o_relu = '0;
        end else if (shifted > RELU_MAX) begin
            o_relu = RELU_MAX[DATA_WIDTH-1:0];
        end else begin
            o_relu = shifted[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        priority if (shifted > SCORE_MAX) begin
            o_score = SCORE_MAX[SCORE_W-1:0];
        end else if (shifted < SCORE_MIN) begin
            o_score = SCORE_MIN[SCORE_W-1:0];
        end else begin
            o_score = shifted[SCORE_W-1:0];
        end
    end

endmodule

// ===== rtl/mbc_seq.sv =====
// Layer sequencer: walks neurons and inputs, issues operands, holds activation stores.
// Depends on mbc_pkg.
module mbc_seq #(
    parameter int N_INPUTS        = 16,
    parameter int N_HIDDEN_FIRST  = 16,
    parameter int N_HIDDEN_SECOND = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_feat_we,
    input  logic [mbc_pkg::PADDR_W-1:0] i_feat_addr,
    input  mbc_pkg::t_data              i_feat_data,
    input  mbc_pkg::t_data              i_relu,
    input  logic                        i_out_free,
    output logic                        o_idle,
    output logic                        o_done,
    output logic [mbc_pkg::PADDR_W-1:0] o_raddr,
    output mbc_pkg::t_mac_ctl           o_ctl,
    output mbc_pkg::t_data              o_x
);
    import mbc_pkg::*;

    localparam int MAX_A  = (N_INPUTS > N_HIDDEN_FIRST) ? N_INPUTS : N_HIDDEN_FIRST;
    localparam int MAX_N  = (MAX_A > N_HIDDEN_SECOND) ? MAX_A : N_HIDDEN_SECOND;
    localparam int CNT_W  = $clog2(MAX_N + 1);
    localparam int FI_W   = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
    localparam int H1_W   = (N_HIDDEN_FIRST > 1) ? $clog2(N_HIDDEN_FIRST) : 1;
    localparam int H2_W   = (N_HIDDEN_SECOND > 1) ? $clog2(N_HIDDEN_SECOND) : 1;

    localparam int W1_BASE  = 0;
    localparam int B1_BASE  = W1_BASE + N_HIDDEN_FIRST * N_INPUTS;
    localparam int W2_BASE  = B1_BASE + N_HIDDEN_FIRST;
    localparam int B2_BASE  = W2_BASE + N_HIDDEN_SECOND * N_HIDDEN_FIRST;
    localparam int W3_BASE  = B2_BASE + N_HIDDEN_SECOND;
    localparam int B3_BASE  = W3_BASE + N_HIDDEN_SECOND;
    localparam int N_PARAMS = B3_BASE + 1;
    localparam int PTR_MIN  = $clog2(N_PARAMS + 1);
    localparam int PTR_W    = (PTR_MIN > PADDR_W + 1) ? PTR_MIN : PADDR_W + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BIAS  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [1:0] LY_FIRST  = 2'd0;
    localparam logic [1:0] LY_SECOND = 2'd1;
    localparam logic [1:0] LY_OUT    = 2'd2;

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_layer, n_layer;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [DRAIN_W-1:0] r_drain, n_drain;
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_bptr, n_bptr;
    t_data              r_x;

    t_data r_feature [N_INPUTS];
    t_data r_hidden1 [N_HIDDEN_FIRST];
    t_data r_hidden2 [N_HIDDEN_SECOND];

    logic [CNT_W-1:0] in_last;
    logic [CNT_W-1:0] out_last;
    logic [PTR_W-1:0] ptr_sel;
    logic             capture;
    t_data            act;

    always_comb begin
        unique case (r_layer)
            LY_FIRST: begin
                in_last  = CNT_W'(N_INPUTS - 1);
                out_last = CNT_W'(N_HIDDEN_FIRST - 1);
            end
            LY_SECOND: begin
                in_last  = CNT_W'(N_HIDDEN_FIRST - 1);
                out_last = CNT_W'(N_HIDDEN_SECOND - 1);
            end
            default: begin
                in_last  = CNT_W'(N_HIDDEN_SECOND - 1);
                out_last = '0;
            end
        endcase
    end

    always_comb begin
        unique case (r_layer)
            LY_FIRST:  act = r_feature[r_j[FI_W-1:0]];
            LY_SECOND: act = r_hidden1[r_j[H1_W-1:0]];
            default:   act = r_hidden2[r_j[H2_W-1:0]];
        endcase
    end

    assign ptr_sel    = (r_state == ST_BIAS) ? r_bptr : r_wptr;
    assign o_raddr    = ptr_sel[PADDR_W-1:0];
    assign o_ctl.valid = (r_state == ST_BIAS) || (r_state == ST_ISSUE);
    assign o_ctl.bias  = (r_state == ST_BIAS);
    assign o_ctl.zero  = (ptr_sel >= PTR_W'(PARAM_DEPTH));
    assign o_x        = r_x;
    assign o_idle     = (r_state == ST_IDLE);
    assign o_done     = (r_state == ST_DONE);

    always_comb begin
        n_state = r_state;
        n_layer = r_layer;
        n_i     = r_i;
        n_j     = r_j;
        n_drain = r_drain;
        n_wptr  = r_wptr;
        n_bptr  = r_bptr;
        capture = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_BIAS;
                    n_layer = LY_FIRST;
                    n_i     = '0;
                    n_wptr  = PTR_W'(W1_BASE);
                    n_bptr  = PTR_W'(B1_BASE);
                end
            end
            ST_BIAS: begin
                n_bptr  = r_bptr + 1'b1;
                n_j     = '0;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                n_wptr = r_wptr + 1'b1;
                if (r_j == in_last) begin
                    n_state = ST_DRAIN;
                    n_drain = '0;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_drain == DRAIN_W'(MAC_LATENCY - 1)) begin
                    capture = 1'b1;
                    priority if (r_layer == LY_OUT) begin
                        n_state = ST_DONE;
                    end else if (r_i == out_last) begin
                        // move on to the next layer
                        n_state = ST_BIAS;
                        n_i     = '0;
                        if (r_layer == LY_FIRST) begin
                            n_layer = LY_SECOND;
                            n_wptr  = PTR_W'(W2_BASE);
                            n_bptr  = PTR_W'(B2_BASE);
                        end else begin
                            n_layer = LY_OUT;
                            n_wptr  = PTR_W'(W3_BASE);
                            n_bptr  = PTR_W'(B3_BASE);
                        end
                    end else begin
                        n_state = ST_BIAS;
                        n_i     = r_i + 1'b1;
                    end
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_layer <= LY_FIRST;
            r_i     <= '0;
            r_j     <= '0;
            r_drain <= '0;
            r_wptr  <= '0;
            r_bptr  <= '0;
        end else begin
            r_state <= n_state;
            r_layer <= n_layer;
            r_i     <= n_i;
            r_j     <= n_j;
            r_drain <= n_drain;
            r_wptr  <= n_wptr;
            r_bptr  <= n_bptr;
        end
    end

    // activation read lines up with the registered parameter read
    always_ff @(posedge i_clk) begin
        r_x <= act;
    end

    always_ff @(posedge i_clk) begin
        if (i_feat_we && (i_feat_addr < PADDR_W'(N_INPUTS))) begin
            r_feature[i_feat_addr[FI_W-1:0]] <= i_feat_data;
        end
        if (capture && (r_layer == LY_FIRST)) begin
            r_hidden1[r_i[H1_W-1:0]] <= i_relu;
        end
        if (capture && (r_layer == LY_SECOND)) begin
            r_hidden2[r_i[H2_W-1:0]] <= i_relu;
        end
    end

endmodule

// ===== rtl/mlp_binary_classifier.sv =====
// Two-hidden-layer perceptron classifier: stream front end, sequencer, MAC, parameter store.
// A start word's result is paced by the single shared multiply-accumulate unit.
// Throughput: one load word per cycle; no word is taken while an inference runs.
// Reset (synchronous, active low) clears control state; stores keep old contents.
module mlp_binary_classifier #(
    parameter int N_INPUTS        = 16,
    parameter int N_HIDDEN_FIRST  = 16,
    parameter int N_HIDDEN_SECOND = 8,
    parameter int FRAC_BITS       = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mbc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [8:0] addr, [24:9] value, rest zero
    input  logic [mbc_pkg::OP_W-1:0]      s_axis_tuser,  // [1:0] opcode
    // master side
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mbc_pkg::M_TDATA_W-1:0] m_axis_tdata   // [0] class_bit, [32:1] score, rest zero
);
    import mbc_pkg::*;

    logic                        s_fire;
    logic [OP_W-1:0]             in_op;
    logic [PADDR_W-1:0]          in_addr;
    t_data                       in_value;

    logic                        seq_idle;
    logic                        seq_done;
    logic [PADDR_W-1:0]          mem_raddr;
    t_data                       mem_rdata;
    t_mac_ctl                    mac_ctl;
    t_data                       mac_x;
    t_data                       mac_relu;
    logic signed [SCORE_W-1:0]   mac_score;

    logic                        out_free;
    logic                        r_out_valid;
    logic [M_TDATA_W-1:0]        r_out_data;

    // Unpack the incoming word
    assign in_op    = s_axis_tuser;
    assign in_addr  = s_axis_tdata[PADDR_W-1:0];
    assign in_value = s_axis_tdata[PADDR_W +: DATA_WIDTH];

    // Take words only while the sequencer sits idle
    assign s_axis_tready = seq_idle;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Parameter writes: a 9-bit address always lies inside the store
    mbc_param_mem u_param_mem (
        .i_clk   (i_clk),
        .i_we    (s_fire && (in_op == OP_PARAM)),
        .i_waddr (in_addr),
        .i_wdata (in_value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer walks every neuron: bias first, then one product per input,
    // then drains the MAC pipeline; a hidden neuron's ReLU output is stored.
    mbc_seq #(
        .N_INPUTS        (N_INPUTS),
        .N_HIDDEN_FIRST  (N_HIDDEN_FIRST),
        .N_HIDDEN_SECOND (N_HIDDEN_SECOND)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_fire && (in_op == OP_START)),
        .i_feat_we   (s_fire && (in_op == OP_FEATURE)),
        .i_feat_addr (in_addr),
        .i_feat_data (in_value),
        .i_relu      (mac_relu),
        .i_out_free  (out_free),
        .o_idle      (seq_idle),
        .o_done      (seq_done),
        .o_raddr     (mem_raddr),
        .o_ctl       (mac_ctl),
        .o_x         (mac_x)
    );

    // Shared multiply-accumulate with 40-bit accumulator
    mbc_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_w     (mem_rdata),
        .i_x     (mac_x),
        .o_relu  (mac_relu),
        .o_score (mac_score)
    );

    // Output register: the sequencer holds in its done state until this frees up
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Class bit is the sigmoid-above-one-half test, i.e. score above zero
    always_ff @(posedge i_clk) begin
        if (seq_done && out_free) begin
            r_out_data <= {{(M_TDATA_W-SCORE_W-1){1'b0}}, mac_score,
                           (mac_score > SCORE_W'(0))};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
